@@ design/csrpad_pkg.sv @@
// Shared types, constants and codes for the CSR channel pad layout block.
package csrpad_pkg;

   localparam int NUM_CHANNELS_DEF = 16;
   localparam int FILL_BITS_DEF    = 30;

   localparam int VERTEX_BITS   = 20;
   localparam int CHAN_BITS     = 4;
   localparam int ADDR_BITS     = 29;
   localparam int ROWPTR_BITS   = 31;
   localparam int WAYS_BITS     = 3;
   localparam int ALIGN_BITS    = 5;
   localparam int CAP_BITS      = 30;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 2;

   localparam logic [REG_IDX_BITS-1:0] REG_INTERLEAVED = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_WAYS_LOG2   = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_ALIGN_WORDS = 2'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_CAPACITY    = 2'd3;

   localparam logic                  INTERLEAVED_RST = 1'b0;
   localparam logic [WAYS_BITS-1:0]  WAYS_LOG2_RST   = 3'd4;
   localparam logic [ALIGN_BITS-1:0] ALIGN_WORDS_RST = 5'd1;
   localparam logic [CAP_BITS-1:0]   CAPACITY_RST    = 30'd67108864;

   typedef enum logic [1:0] {
      KIND_EDGE     = 2'd0,
      KIND_PAD      = 2'd1,
      KIND_ROWPTR   = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE,
      ST_SCAN,
      ST_DIV,
      ST_ROUND,
      ST_PAD,
      ST_PTR
   } state_type;

   typedef struct packed {
      logic                   mode;
      logic [VERTEX_BITS-1:0] vertex_id;
   } req_type;

   typedef struct packed {
      kind_type               kind;
      logic [CHAN_BITS-1:0]   channel;
      logic [ADDR_BITS-1:0]   address;
      logic [VERTEX_BITS-1:0] neighbor;
      logic [ADDR_BITS-1:0]   pad_count;
      logic [ROWPTR_BITS-1:0] row_pointer;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic                  interleaved_layout;
      logic [WAYS_BITS-1:0]  ways_log2;
      logic [ALIGN_BITS-1:0] align_words;
      logic [CAP_BITS-1:0]   channel_capacity;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic idx_clr;
      logic idx_inc;
      logic tgt_max;
      logic div_start;
      logic div_step;
      logic tgt_round;
      logic emit_edge;
      logic emit_pad;
      logic emit_ptr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic idx_last;
      logic pad_need;
      logic div_last;
      logic interleaved;
   } dp_status_type;

endpackage

@@ design/csrpad_csr.sv @@
// Configuration register file with its APB-style access port.
module csrpad_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [csrpad_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [csrpad_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [csrpad_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                   pready,
   output csrpad_pkg::cfg_type                    cfg
);
   import csrpad_pkg::*;

   logic                    interleaved_ff, interleaved_in;
   logic [WAYS_BITS-1:0]    ways_log2_ff, ways_log2_in;
   logic [ALIGN_BITS-1:0]   align_ff, align_in;
   logic [CAP_BITS-1:0]     capacity_ff, capacity_in;
   logic [REG_IDX_BITS-1:0] reg_idx;
   logic                    wr_en;

   assign reg_idx = paddr[CSR_ADDR_BITS-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_comb begin
      interleaved_in = interleaved_ff;
      ways_log2_in   = ways_log2_ff;
      align_in       = align_ff;
      capacity_in    = capacity_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_INTERLEAVED: interleaved_in = pwdata[0];
            REG_WAYS_LOG2:   ways_log2_in   = pwdata[WAYS_BITS-1:0];
            REG_ALIGN_WORDS: align_in       = pwdata[ALIGN_BITS-1:0];
            REG_CAPACITY:    capacity_in    = pwdata[CAP_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interleaved_ff <= INTERLEAVED_RST;
         ways_log2_ff   <= WAYS_LOG2_RST;
         align_ff       <= ALIGN_WORDS_RST;
         capacity_ff    <= CAPACITY_RST;
      end else begin
         interleaved_ff <= interleaved_in;
         ways_log2_ff   <= ways_log2_in;
         align_ff       <= align_in;
         capacity_ff    <= capacity_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_INTERLEAVED: prdata = CSR_DATA_BITS'(interleaved_ff);
         REG_WAYS_LOG2:   prdata = CSR_DATA_BITS'(ways_log2_ff);
         REG_ALIGN_WORDS: prdata = CSR_DATA_BITS'(align_ff);
         REG_CAPACITY:    prdata = CSR_DATA_BITS'(capacity_ff);
      endcase
   end

   assign cfg.interleaved_layout = interleaved_ff;
   assign cfg.ways_log2          = ways_log2_ff;
   assign cfg.align_words        = align_ff;
   assign cfg.channel_capacity   = capacity_ff;

endmodule

@@ design/csrpad_ctrl.sv @@
// Controller state machine sequencing edge writes, row-end scan, remainder, rounding, pads and row pointer.
module csrpad_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_mode,
   output logic                      req_ready,
   input  csrpad_pkg::dp_status_type status,
   output csrpad_pkg::ctrl_cmd_type  cmd
);
   import csrpad_pkg::*;

   state_type state_ff, state_in;
   logic      pad_adv;

   assign pad_adv = !status.pad_need || status.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_mode ? ST_SCAN : ST_EDGE;
            end
         end
         ST_EDGE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.idx_last) begin
               state_in = status.interleaved ? ST_PAD : ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: state_in = ST_PAD;
         ST_PAD: begin
            if (pad_adv && status.idx_last) begin
               state_in = ST_PTR;
            end
         end
         ST_PTR: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EDGE: cmd.emit_edge = status.out_free;
         ST_SCAN: begin
            cmd.tgt_max   = 1'b1;
            cmd.idx_inc   = !status.idx_last;
            cmd.idx_clr   = status.idx_last && status.interleaved;
            cmd.div_start = status.idx_last && !status.interleaved;
         end
         ST_DIV: cmd.div_step = 1'b1;
         ST_ROUND: begin
            cmd.tgt_round = 1'b1;
            cmd.idx_clr   = 1'b1;
         end
         ST_PAD: begin
            cmd.emit_pad = status.pad_need && status.out_free;
            cmd.idx_inc  = pad_adv && !status.idx_last;
         end
         ST_PTR: cmd.emit_ptr = status.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/csrpad_dp.sv @@
// Datapath: channel fill memory, target and remainder units, result register.
module csrpad_dp #(
   parameter int NUM_CHANNELS = csrpad_pkg::NUM_CHANNELS_DEF,
   parameter int FILL_BITS    = csrpad_pkg::FILL_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  csrpad_pkg::cfg_type       cfg,
   input  csrpad_pkg::ctrl_cmd_type  cmd,
   output csrpad_pkg::dp_status_type status,
   input  csrpad_pkg::req_type       req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output csrpad_pkg::rsp_type       rsp_data
);
   import csrpad_pkg::*;

   localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int MEM_DEPTH = 1 << CH_IDX_W;
   localparam int MAX_LOG2  = $clog2(NUM_CHANNELS + 1) - 1;
   localparam int WIDE_W    = FILL_BITS + 32;
   localparam int CNT_W     = $clog2(FILL_BITS);

   logic [FILL_BITS-1:0]   fill_mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]   fill_vld_ff, fill_vld_in;
   logic [FILL_BITS-1:0]   rd_data_ff;
   logic                   rd_vld_ff;
   logic [CH_IDX_W-1:0]    idx_ff, idx_in;
   logic [VERTEX_BITS-1:0] vid_ff, vid_in;
   logic [FILL_BITS-1:0]   target_ff, target_in;
   logic [FILL_BITS-1:0]   row_max_ff, row_max_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ALIGN_BITS-1:0]  rem_ff, rem_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [WAYS_BITS-1:0]   l_max, l_eff;
   logic [CH_IDX_W:0]      ways_one;
   logic [CH_IDX_W-1:0]    ways_mask;
   logic [CH_IDX_W-1:0]    req_ch;
   logic [FILL_BITS-1:0]   fill_cur;
   logic [ALIGN_BITS-1:0]  align_eff;
   logic [ALIGN_BITS:0]    rem_sh;
   logic [ALIGN_BITS-1:0]  rem_adj;
   logic [FILL_BITS:0]     round_sum;
   logic [WIDE_W-1:0]      slot_wide, addr_wide, ch_wide, diff_wide, rp_wide;
   logic                   cap_hit;
   logic                   fill_we;
   logic [FILL_BITS-1:0]   fill_wdata;

   assign l_max     = WAYS_BITS'(MAX_LOG2);
   assign l_eff     = (cfg.ways_log2 > l_max) ? l_max : cfg.ways_log2;
   assign ways_one  = (CH_IDX_W + 1)'(1) << l_eff;
   assign ways_mask = ways_one[CH_IDX_W-1:0] - 1'b1;
   assign req_ch    = req_data.vertex_id[CH_IDX_W-1:0] & ways_mask;
   assign fill_cur  = rd_vld_ff ? rd_data_ff : '0;
   assign align_eff = (cfg.align_words == '0) ? ALIGN_BITS'(1) : cfg.align_words;

   assign slot_wide = WIDE_W'(fill_cur);
   assign ch_wide   = WIDE_W'(idx_ff);
   assign addr_wide = cfg.interleaved_layout ? ((slot_wide << l_eff) | ch_wide) : slot_wide;
   assign diff_wide = WIDE_W'(target_ff - fill_cur);
   assign rp_wide   = WIDE_W'(target_ff) << l_eff;
   assign cap_hit   = slot_wide >= WIDE_W'(cfg.channel_capacity);

   assign rem_sh    = {rem_ff, target_ff[cnt_ff]};
   assign rem_adj   = (rem_ff == '0) ? '0 : align_eff - rem_ff;
   assign round_sum = {1'b0, target_ff} + (FILL_BITS + 1)'(rem_adj);

   assign fill_we    = (cmd.emit_edge && !cap_hit) || cmd.emit_pad;
   assign fill_wdata = cmd.emit_pad ? target_ff : fill_cur + 1'b1;

   assign status.out_free    = !rsp_valid_ff || rsp_ready;
   assign status.idx_last    = idx_ff == ways_mask;
   assign status.pad_need    = fill_cur < target_ff;
   assign status.div_last    = cnt_ff == '0;
   assign status.interleaved = cfg.interleaved_layout;

   always_comb begin
      priority if (cmd.load) begin
         idx_in = req_data.mode ? '0 : req_ch;
      end else if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_comb begin
      vid_in      = cmd.load ? req_data.vertex_id : vid_ff;
      row_max_in  = cmd.emit_ptr ? target_ff : row_max_ff;
      fill_vld_in = fill_vld_ff;
      if (fill_we) begin
         fill_vld_in[idx_ff] = 1'b1;
      end
      unique if (cmd.load) begin
         target_in = row_max_ff;
      end else if (cmd.tgt_max) begin
         target_in = (fill_cur > target_ff) ? fill_cur : target_ff;
      end else if (cmd.tgt_round) begin
         target_in = round_sum[FILL_BITS] ? '1 : round_sum[FILL_BITS-1:0];
      end else begin
         target_in = target_ff;
      end
      unique if (cmd.div_start) begin
         cnt_in = CNT_W'(FILL_BITS - 1);
         rem_in = '0;
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff - 1'b1;
         if (rem_sh >= {1'b0, align_eff}) begin
            rem_in = ALIGN_BITS'(rem_sh - {1'b0, align_eff});
         end else begin
            rem_in = rem_sh[ALIGN_BITS-1:0];
         end
      end else begin
         cnt_in = cnt_ff;
         rem_in = rem_ff;
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      unique if (cmd.emit_edge) begin
         rsp_data_in             = '0;
         rsp_data_in.kind        = cap_hit ? KIND_OVERFLOW : KIND_EDGE;
         rsp_data_in.channel     = ch_wide[CHAN_BITS-1:0];
         rsp_data_in.address     = cap_hit ? '0 : addr_wide[ADDR_BITS-1:0];
         rsp_data_in.neighbor    = vid_ff;
         rsp_data_in.last        = 1'b1;
      end else if (cmd.emit_pad) begin
         rsp_data_in             = '0;
         rsp_data_in.kind        = KIND_PAD;
         rsp_data_in.channel     = ch_wide[CHAN_BITS-1:0];
         rsp_data_in.address     = addr_wide[ADDR_BITS-1:0];
         rsp_data_in.pad_count   = diff_wide[ADDR_BITS-1:0];
      end else if (cmd.emit_ptr) begin
         rsp_data_in             = '0;
         rsp_data_in.kind        = KIND_ROWPTR;
         rsp_data_in.row_pointer = rp_wide[ROWPTR_BITS-1:0];
         rsp_data_in.last        = 1'b1;
      end else begin
         rsp_data_in = rsp_data_ff;
      end
   end

   always_comb begin
      if (cmd.emit_edge || cmd.emit_pad || cmd.emit_ptr) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[idx_ff] <= fill_wdata;
      end
      rd_data_ff <= fill_mem[idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_vld_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         idx_ff       <= '0;
         row_max_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_vld_ff  <= fill_vld_in;
         rd_vld_ff    <= fill_vld_ff[idx_in];
         idx_ff       <= idx_in;
         row_max_ff   <= row_max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vid_ff      <= vid_in;
      target_ff   <= target_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/csr_channel_pad_layout.sv @@
// Top level of the CSR channel pad layout block: registers, controller, datapath.
// Edge beat: the result is registered once the output is free; no new request is taken until it issues.
// Row end: a scan of the active ways for the row maximum, then in banked mode a bit-serial
// remainder and a rounding step, then pads for ways below target, then a row pointer beat.
// Throughput is set by the single read port of the fill memory and the bit-serial remainder.
// Reset is synchronous: clears state, fill valid bits and row max; registers take reset values.
module csr_channel_pad_layout #(
   parameter int NUM_CHANNELS = csrpad_pkg::NUM_CHANNELS_DEF,
   parameter int FILL_BITS    = csrpad_pkg::FILL_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  csrpad_pkg::req_type                  req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output csrpad_pkg::rsp_type                  rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [csrpad_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [csrpad_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [csrpad_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                 pready
);
   import csrpad_pkg::*;

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   csrpad_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   csrpad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   csrpad_dp #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .FILL_BITS    (FILL_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/csrpad_checker.sv @@
// Port-level checker for the CSR channel pad layout block, with its bind.
module csrpad_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input csrpad_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input csrpad_pkg::rsp_type rsp_data
);
   import csrpad_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an accepted beat");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.kind != KIND_PAD)))
      else $error("last flag does not match result kind");

   a_rowptr_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_ROWPTR |->
         rsp_data.channel == '0 && rsp_data.address == '0 &&
         rsp_data.pad_count == '0 && rsp_data.neighbor == '0)
      else $error("row pointer beat carries stray fields");

endmodule

bind csr_channel_pad_layout csrpad_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
